// ===== hdl/plca_pkg.sv =====
// ----------------------------------------------------------------------------
// plca_pkg
// Shared types and constants of the partition layout / CHS allocator.
// ----------------------------------------------------------------------------
package plca_pkg;

  // Largest table size the block lays out by default
  localparam int unsigned PLCA_MAX_PARTS = 128;

  // Field and datapath widths
  localparam int unsigned SIZE_W   = 31;
  localparam int unsigned LBA_W    = 32;
  localparam int unsigned CHS_W    = 24;
  localparam int unsigned DVS_W    = 17;  // widest divisor: 2 * align_kb
  localparam int unsigned STEP_W   = 5;   // one quotient bit per cycle, 32 steps
  localparam int unsigned CFG_A_W  = 3;
  localparam int unsigned CFG_D_W  = 16;
  localparam int unsigned IN_D_W   = 40;
  localparam int unsigned OUT_D_W  = 136;

  localparam logic [7:0] BOOT_ACTIVE = 8'h80;
  localparam logic [2:0] ACTIVE_MAX  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_HEAD_COUNT = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_SPT        = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_ALIGN_KB   = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_ACTIVE     = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_SKIP_EMPTY = 3'd4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SKIPPED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_TOO_MANY = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_ALN_DIV  = 15'h0002,
    S_ALN_FIX  = 15'h0004,
    S_END      = 15'h0008,
    S_CYL_DIV  = 15'h0010,
    S_CYL_FIX  = 15'h0020,
    S_C0A_DIV  = 15'h0040,
    S_C0A_POST = 15'h0080,
    S_C0B_DIV  = 15'h0100,
    S_C0B_POST = 15'h0200,
    S_C1A_DIV  = 15'h0400,
    S_C1A_POST = 15'h0800,
    S_C1B_DIV  = 15'h1000,
    S_C1B_POST = 15'h2000,
    S_FIN      = 15'h4000
  } state_t;

endpackage

// ===== hdl/partition_layout_chs_allocator.sv =====
// ----------------------------------------------------------------------------
// partition_layout_chs_allocator
// Lays out an MBR-style partition table one request at a time and converts
// the first and last sector of each entry to packed CHS.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: size_kb, part_type; tlast: last
//  out_    | out | out_tvalid/tready  | tdata: index..chs_last; tuser: status
//  cfg_    | in  | cfg_wr_en          | cfg_addr selects register, cfg_wdata
//
//  A regular request runs five divisions (alignment or cylinder rounding,
//  then sector and head split for both CHS values) one after another on a
//  single restoring divider, between its setup and commit states. Empty and
//  overflow requests go straight to the final state. There the result is
//  loaded into the output register and the sequencer returns to idle in the
//  same cycle, so the input is ready again as the result shows. Reset
//  (rst_n low, synchronous) loads the default geometry and clears the
//  running sector and entry count. A stalled result sits in the output
//  register; the next request is accepted meanwhile and waits in the final
//  state only if its own result would overwrite an untaken one.
//
module partition_layout_chs_allocator
  import plca_pkg::*;
#(
  parameter int unsigned MAX_PARTS = PLCA_MAX_PARTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // size_kb [30:0], part_type [38:31], zero pad [39]
  input  logic [IN_D_W-1:0]    in_tdata,
  input  logic                 in_tlast,   // last_part
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // entry_index [6:0], boot_flag [14:7], type_out [22:15], start_lba [54:23],
  // length_sectors [86:55], chs_first [110:87], chs_last [134:111], pad [135]
  output logic [OUT_D_W-1:0]   out_tdata,
  output logic [1:0]           out_tuser,  // status
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_wr_en,
  input  logic [CFG_A_W-1:0]   cfg_addr,
  input  logic [CFG_D_W-1:0]   cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(MAX_PARTS + 1);

  // Configuration registers
  logic [7:0]  head_count_r;
  logic [5:0]  spt_r;
  logic [15:0] align_kb_r;
  logic [2:0]  active_r;
  logic        skip_empty_r;

  // Running layout state
  logic [LBA_W-1:0] next_sec_r, next_sec_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Sequencer and item registers
  state_t           state_r, state_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [7:0]       type_r, type_nxt;
  logic             last_r, last_nxt;
  status_t          status_r, status_nxt;
  logic [LBA_W-1:0] start_r, start_nxt;
  logic [LBA_W-1:0] end_r, end_nxt;
  logic [5:0]       sec_r, sec_nxt;
  logic [CHS_W-1:0] chs0_r, chs0_nxt;
  logic [CHS_W-1:0] chs1_r, chs1_nxt;

  // Shared divider
  logic [LBA_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_D_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]         out_user_r, out_user_nxt;

  // Effective geometry: zero heads or sectors count as one
  logic [7:0]       heads_eff;
  logic [5:0]       spt_eff;
  logic [13:0]      cyl_sec;
  logic [DVS_W-1:0] align_sec;

  assign heads_eff = (head_count_r == 8'd0) ? 8'd1 : head_count_r;
  assign spt_eff   = (spt_r == 6'd0) ? 6'd1 : spt_r;
  assign cyl_sec   = {6'd0, heads_eff} * {8'd0, spt_eff};
  assign align_sec = {align_kb_r, 1'b0};

  // One restoring step: shift in the next dividend bit, subtract if it fits
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;
  logic [DVS_W-1:0]  rem_step;
  logic [LBA_W-1:0]  quo_step;
  logic              step_last;

  assign trial     = {rem_r, quo_r[LBA_W-1]};
  assign diff      = trial - {1'b0, dvs_r};
  assign fits      = (trial >= {1'b0, dvs_r});
  assign rem_step  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  assign quo_step  = {quo_r[LBA_W-2:0], fits};
  assign step_last = &step_r;

  // Result assembly helpers
  logic             is_ok;
  logic [6:0]       idx_out;
  logic [7:0]       boot_out;
  logic [7:0]       cnt8;
  logic [LBA_W-1:0] len_sec;
  logic             in_fire;
  logic             out_free;

  assign cnt8     = 8'(cnt_r);
  assign is_ok    = (status_r == ST_OK);
  assign idx_out  = (status_r == ST_TOO_MANY) ? 7'd0 : cnt8[6:0];
  assign boot_out = (is_ok && active_r <= ACTIVE_MAX && (cnt8 + 8'd1) == {5'd0, active_r})
                    ? BOOT_ACTIVE : 8'd0;
  assign len_sec  = end_r - start_r;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    type_nxt      = type_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    sec_nxt       = sec_r;
    chs0_nxt      = chs0_r;
    chs1_nxt      = chs1_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    step_nxt      = step_r;
    next_sec_nxt  = next_sec_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          size_nxt = in_tdata[SIZE_W-1:0];
          type_nxt = in_tdata[SIZE_W+7:SIZE_W];
          last_nxt = in_tlast;
          if (cnt_r >= CNT_W'(MAX_PARTS)) begin
            status_nxt = ST_TOO_MANY;
            state_nxt  = S_FIN;
          end else if (in_tdata[SIZE_W-1:0] == '0) begin
            status_nxt = skip_empty_r ? ST_SKIPPED : ST_EMPTY;
            state_nxt  = S_FIN;
          end else begin
            // open one track after the running end
            status_nxt = ST_OK;
            start_nxt  = next_sec_r + {26'd0, spt_eff};
            if (align_kb_r != 16'd0) begin
              quo_nxt   = next_sec_r + {26'd0, spt_eff};
              rem_nxt   = '0;
              dvs_nxt   = align_sec;
              step_nxt  = '0;
              state_nxt = S_ALN_DIV;
            end else begin
              state_nxt = S_END;
            end
          end
        end
      end

      S_ALN_DIV, S_CYL_DIV, S_C0A_DIV, S_C0B_DIV, S_C1A_DIV, S_C1B_DIV: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + STEP_W'(1);
        if (step_last) begin
          case (state_r)
            S_ALN_DIV: state_nxt = S_ALN_FIX;
            S_CYL_DIV: state_nxt = S_CYL_FIX;
            S_C0A_DIV: state_nxt = S_C0A_POST;
            S_C0B_DIV: state_nxt = S_C0B_POST;
            S_C1A_DIV: state_nxt = S_C1A_POST;
            default:   state_nxt = S_C1B_POST;
          endcase
        end
      end

      S_ALN_FIX: begin
        // round the start up to the alignment
        if (rem_r != '0) begin
          start_nxt = start_r + LBA_W'(dvs_r) - LBA_W'(rem_r);
        end
        state_nxt = S_END;
      end

      S_END: begin
        end_nxt  = start_r + {size_r, 1'b0};
        rem_nxt  = '0;
        step_nxt = '0;
        if (align_kb_r == 16'd0) begin
          quo_nxt   = start_r + {size_r, 1'b0};
          dvs_nxt   = DVS_W'(cyl_sec);
          state_nxt = S_CYL_DIV;
        end else begin
          quo_nxt   = start_r;
          dvs_nxt   = DVS_W'(spt_eff);
          state_nxt = S_C0A_DIV;
        end
      end

      S_CYL_FIX: begin
        // push the end to the next cylinder, always by at least one sector
        end_nxt   = end_r + LBA_W'(dvs_r) - LBA_W'(rem_r);
        quo_nxt   = start_r;
        rem_nxt   = '0;
        dvs_nxt   = DVS_W'(spt_eff);
        step_nxt  = '0;
        state_nxt = S_C0A_DIV;
      end

      S_C0A_POST, S_C1A_POST: begin
        sec_nxt   = rem_r[5:0] + 6'd1;
        rem_nxt   = '0;
        dvs_nxt   = DVS_W'(heads_eff);
        step_nxt  = '0;
        state_nxt = (state_r == S_C0A_POST) ? S_C0B_DIV : S_C1B_DIV;
      end

      S_C0B_POST: begin
        chs0_nxt  = {rem_r[7:0], quo_r[9:8], sec_r, quo_r[7:0]};
        quo_nxt   = end_r - LBA_W'(1);
        rem_nxt   = '0;
        dvs_nxt   = DVS_W'(spt_eff);
        step_nxt  = '0;
        state_nxt = S_C1A_DIV;
      end

      S_C1B_POST: begin
        chs1_nxt  = {rem_r[7:0], quo_r[9:8], sec_r, quo_r[7:0]};
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // hold until the output register is free, then commit the entry
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = status_r;
          out_data_nxt  = {1'b0,
                           is_ok ? chs1_r  : '0,
                           is_ok ? chs0_r  : '0,
                           is_ok ? len_sec : '0,
                           is_ok ? start_r : '0,
                           is_ok ? type_r  : 8'd0,
                           boot_out,
                           idx_out};
          if (is_ok) begin
            next_sec_nxt = end_r;
          end
          if (status_r != ST_TOO_MANY) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (last_r) begin
            next_sec_nxt = '0;
            cnt_nxt      = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      next_sec_r  <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      next_sec_r  <= next_sec_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload and divider registers
  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    type_r     <= type_nxt;
    last_r     <= last_nxt;
    status_r   <= status_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    sec_r      <= sec_nxt;
    chs0_r     <= chs0_nxt;
    chs1_r     <= chs1_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_count_r <= 8'd16;
      spt_r        <= 6'd63;
      align_kb_r   <= 16'd0;
      active_r     <= 3'd1;
      skip_empty_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_HEAD_COUNT: head_count_r <= cfg_wdata[7:0];
        REG_SPT:        spt_r        <= cfg_wdata[5:0];
        REG_ALIGN_KB:   align_kb_r   <= cfg_wdata;
        REG_ACTIVE:     active_r     <= cfg_wdata[2:0];
        REG_SKIP_EMPTY: skip_empty_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

endmodule

// ===== test/plca_layout_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plca_layout_checker
// Watches the request, result and register ports of the partition allocator.
// It keeps its own copy of the geometry registers and of the running table
// state, predicts every entry when its request is accepted, and compares each
// result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module plca_layout_checker
  import plca_pkg::*;
#(
  parameter int unsigned MAX_PARTS = PLCA_MAX_PARTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [IN_D_W-1:0]  in_tdata,
  input  logic               in_tlast,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [OUT_D_W-1:0] out_tdata,
  input  logic [1:0]         out_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic               cfg_wr_en,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata,
  output int                 mismatches,
  output int                 entries_due
);

  typedef struct {
    status_t     status;
    logic [6:0]  index;
    logic [7:0]  boot;
    logic [7:0]  ptype;
    logic [31:0] start;
    logic [31:0] length;
    logic [23:0] chs_first;
    logic [23:0] chs_last;
  } entry_t;

  logic [7:0]  heads_r;
  logic [5:0]  spt_r;
  logic [15:0] align_r;
  logic [2:0]  active_r;
  logic        skip_r;
  logic [31:0] run_end;
  int unsigned entries_used;
  entry_t      predicted_entries[$];
  int          errs = 0;

  function automatic logic [23:0] chs_of(logic [31:0] lba, logic [31:0] heads,
                                         logic [31:0] spt);
    logic [31:0] sec, rest, head, cyl;
    sec  = lba % spt + 32'd1;
    rest = lba / spt;
    head = rest % heads;
    cyl  = rest / heads;
    // cylinder bits 9:8 ride in the top of the sector byte, higher bits drop
    return {head[7:0], sec[7:0] | {cyl[9:8], 6'd0}, cyl[7:0]};
  endfunction

  function automatic entry_t lay_out_entry(logic [30:0] size, logic [7:0] ptype,
                                           logic last);
    entry_t      e;
    logic [31:0] heads, spt, start, stop, step, cyl;
    heads       = (heads_r == 8'd0) ? 32'd1 : {24'd0, heads_r};
    spt         = (spt_r == 6'd0) ? 32'd1 : {26'd0, spt_r};
    e.status    = ST_OK;
    e.index     = '0;
    e.boot      = '0;
    e.ptype     = '0;
    e.start     = '0;
    e.length    = '0;
    e.chs_first = '0;
    e.chs_last  = '0;
    if (entries_used >= MAX_PARTS) begin
      e.status = ST_TOO_MANY;
    end else if (size == '0) begin
      // empty request burns an index but leaves the running sector alone
      e.status = skip_r ? ST_SKIPPED : ST_EMPTY;
      e.index  = entries_used[6:0];
      entries_used++;
    end else begin
      start = run_end + spt;
      if (align_r != 16'd0) begin
        step = {15'd0, align_r, 1'b0};
        if (start % step != 32'd0) start = start + step - start % step;
      end
      stop = start + {size, 1'b0};
      if (align_r == 16'd0) begin
        cyl  = heads * spt;
        stop = stop + cyl - stop % cyl;
      end
      e.index     = entries_used[6:0];
      e.boot      = (active_r <= ACTIVE_MAX && entries_used + 1 == active_r) ?
                    BOOT_ACTIVE : 8'd0;
      e.ptype     = ptype;
      e.start     = start;
      e.length    = stop - start;
      e.chs_first = chs_of(start, heads, spt);
      e.chs_last  = chs_of(stop - 32'd1, heads, spt);
      run_end     = stop;
      entries_used++;
    end
    if (last) begin
      run_end      = '0;
      entries_used = 0;
    end
    return e;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    entry_t want;
    if (!rst_n) begin
      heads_r      = 8'd16;
      spt_r        = 6'd63;
      align_r      = 16'd0;
      active_r     = 3'd1;
      skip_r       = 1'b0;
      run_end      = '0;
      entries_used = 0;
      predicted_entries.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_HEAD_COUNT: heads_r  = cfg_wdata[7:0];
          REG_SPT:        spt_r    = cfg_wdata[5:0];
          REG_ALIGN_KB:   align_r  = cfg_wdata[15:0];
          REG_ACTIVE:     active_r = cfg_wdata[2:0];
          REG_SKIP_EMPTY: skip_r   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (predicted_entries.size() == 0) begin
          $error("result transaction with no request outstanding");
          errs++;
        end else begin
          want = predicted_entries.pop_front();
          check_field("status", 32'(want.status), 32'(out_tuser));
          check_field("entry_index", 32'(want.index), 32'(out_tdata[6:0]));
          check_field("boot_flag", 32'(want.boot), 32'(out_tdata[14:7]));
          check_field("type_out", 32'(want.ptype), 32'(out_tdata[22:15]));
          check_field("start_lba", want.start, out_tdata[54:23]);
          check_field("length_sectors", want.length, out_tdata[86:55]);
          check_field("chs_first", 32'(want.chs_first), 32'(out_tdata[110:87]));
          check_field("chs_last", 32'(want.chs_last), 32'(out_tdata[134:111]));
        end
      end
      if (in_tvalid && in_tready) begin
        predicted_entries.push_back(lay_out_entry(in_tdata[30:0], in_tdata[38:31],
                                                  in_tlast));
      end
    end
    mismatches  <= errs;
    entries_due <= predicted_entries.size();
  end

endmodule

// ===== test/partition_layout_chs_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// partition_layout_chs_allocator_tb
// Drives partition requests into the allocator under several disk geometries
// and alignment settings, with random gaps on the request side and random
// back-pressure on the result side. A checker beside the block predicts and
// compares every entry; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module partition_layout_chs_allocator_tb;
  import plca_pkg::*;

  localparam int unsigned STALL_PCT      = 29;    // idle chance per cycle, percent
  localparam int unsigned QUIET_LIMIT    = 5000;  // cycles without any transaction
  localparam int unsigned PHASE_REQUESTS = 64;
  localparam int unsigned LONG_TABLE     = 132;   // runs past the entry limit
  localparam int unsigned NUM_SETTINGS   = 8;
  localparam int unsigned SETTLE_CYCLES  = 200;   // a little over one full entry

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  // size_kb [30:0], part_type [38:31], zero pad [39]
  logic [IN_D_W-1:0]    in_tdata   = '0;
  logic                 in_tlast   = 1'b0;       // last_part
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  // entry_index [6:0], boot_flag [14:7], type_out [22:15], start_lba [54:23],
  // length_sectors [86:55], chs_first [110:87], chs_last [134:111], pad [135]
  logic [OUT_D_W-1:0]   out_tdata;
  logic [1:0]           out_tuser;               // status
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_A_W-1:0]   cfg_addr   = REG_HEAD_COUNT;
  logic [CFG_D_W-1:0]   cfg_wdata  = '0;

  int mismatches;
  int entries_due;
  int requests_sent = 0;
  int quiet_cycles  = 0;
  bit steady        = 1'b0;   // no idling on either side while set

  partition_layout_chs_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  plca_layout_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .entries_due (entries_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Random back-pressure on results; none during the steady stretch
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request and hold it until the block takes the transaction
  task automatic send_request(input logic [30:0] size, input logic [7:0] ptype,
                              input logic last);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {1'b0, ptype, size};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  // Drop valid and hold until every predicted entry has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (entries_due != 0);
  endtask

  // Write all five registers back to back; only called with nothing in flight
  task automatic write_setting(input logic [7:0] heads, input logic [5:0] spt,
                               input logic [15:0] align, input logic [2:0] active,
                               input logic skip);
    logic [CFG_A_W-1:0] regs [5];
    logic [CFG_D_W-1:0] vals [5];
    regs = '{REG_HEAD_COUNT, REG_SPT, REG_ALIGN_KB, REG_ACTIVE, REG_SKIP_EMPTY};
    vals = '{16'(heads), 16'(spt), align, 16'(active), 16'(skip)};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly small and medium sizes, with empties, the maximum and full-range noise
  function automatic logic [30:0] random_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    else if (pick < 45) return 31'($urandom_range(4096, 1));
    else if (pick < 70) return 31'($urandom_range(1 << 20, 1));
    else if (pick < 78) return '1;
    else return 31'($urandom());
  endfunction

  // Lay out short tables until the count is reached; optionally open with one
  // table that overruns the entry limit, and drain once halfway through
  task automatic run_tables(input int unsigned count, input bit with_long,
                            input bit pause_midway);
    int unsigned done_here;
    int unsigned len;
    bit          paused;
    logic        last;
    done_here = 0;
    paused    = 1'b0;
    if (with_long) begin
      for (int i = 0; i < LONG_TABLE; i++) begin
        send_request(31'($urandom_range(64)), 8'($urandom()), i == LONG_TABLE - 1);
      end
      done_here += LONG_TABLE;
    end
    while (done_here < count) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        // now and then misplace the end marker to break the table early or run on
        last = (i == len - 1) ^ ($urandom_range(99) < 5);
        send_request(random_size(), 8'($urandom()), last);
      end
      done_here += len;
      if (pause_midway && !paused && done_here >= count / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: 16 heads, 63 sectors, cylinder rounding, entry 1 bootable
    send_request(31'd1, 8'h83, 1'b0);          // smallest entry, gets the boot flag
    send_request('1, 8'hFF, 1'b0);             // largest size
    send_request('0, 8'h0C, 1'b0);             // empty request gets the empty status
    send_request('1, 8'h07, 1'b0);             // running sector wraps past 2^32
    send_request(31'h2AAAAAAA, 8'h55, 1'b0);
    send_request(31'h55555555, 8'hAA, 1'b0);
    send_request(31'd504, 8'h0B, 1'b1);        // end marker clears the table
    send_request(31'd2048, 8'h00, 1'b0);       // fresh table starts at index zero
    send_request(31'h40000000, 8'h82, 1'b1);   // cylinder far beyond 1023
    run_tables(PHASE_REQUESTS, 1'b0, 1'b0);

    for (int p = 1; p < NUM_SETTINGS; p++) begin
      drain();
      case (p)
        1: write_setting(8'd255, 6'd63, 16'd0, 3'd4, 1'b1);
        2: write_setting(8'd1, 6'd1, 16'd0, 3'd0, 1'b0);
        3: write_setting(8'd0, 6'd0, 16'd1, 3'd7, 1'b1);   // zero geometry, no boot
        4: write_setting(8'd16, 6'd63, 16'hFFFF, 3'd2, 1'b0);
        5: write_setting(8'($urandom_range(255)), 6'($urandom_range(63)),
                         $urandom_range(1) ? 16'($urandom_range(64)) :
                                             16'($urandom_range(65535)),
                         3'($urandom_range(7)), 1'($urandom_range(1)));
        6: write_setting(8'd128, 6'd32, 16'd1024, 3'd3, 1'b1);
        default: write_setting(8'd255, 6'd63, 16'd2048, 3'd1, 1'b0);
      endcase
      steady <= (p == 6);
      run_tables(PHASE_REQUESTS, p == 1 || p == 4, p == 4);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d partition requests under %0d register settings.",
             requests_sent, NUM_SETTINGS);
    $display("Included empties, wraps, overrun tables, zero geometry and stalls.");
    if (mismatches == 0 && entries_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== partition_layout_chs_allocator.f =====
hdl/plca_pkg.sv
hdl/partition_layout_chs_allocator.sv
test/plca_layout_checker.sv
test/partition_layout_chs_allocator_tb.sv
